>>> hdl/frba_pkg.sv
// ----------------------------------------------------------------------------
// frba_pkg
// Shared types and constants of the fenced ring buffer allocator.
// ----------------------------------------------------------------------------
package frba_pkg;

  localparam int unsigned FENCE_SLOTS_DEF = 16;
  localparam int unsigned MAX_ALIGN_DEF   = 256;
  localparam int unsigned OFF_W           = 25;
  localparam int unsigned FENCE_W         = 64;
  localparam int unsigned ALIGN_W         = 9;
  localparam logic [OFF_W-1:0] BUF_SIZE_RST = 25'd65536;

  typedef enum logic [2:0] {
    ST_PLACED     = 3'd0,
    ST_WAITED     = 3'd1,
    ST_SUBMIT     = 3'd2,
    ST_TOO_LARGE  = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_OVERRUN    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LASTRD,
    S_LASTCHK,
    S_RETRD,
    S_RETCHK,
    S_PUSH,
    S_PLACE,
    S_SRCHRD,
    S_SRCHCHK,
    S_FIX,
    S_DONE
  } fsm_e;

endpackage

>>> hdl/fenced_ring_buffer_allocator.sv
// ----------------------------------------------------------------------------
// fenced_ring_buffer_allocator
// Ring buffer space allocator whose consumer is tracked by fence values.
// ----------------------------------------------------------------------------
// Usage: present a word on the command ports with start high while busy
// is low. A reserve (command 0) or commit (command 1) yields exactly one
// result word, shown for one cycle with done_o high. The receiver cannot
// stall; the result is simply presented and then dropped.
// A commit or an early rejection passes only the check and done states; the
// result is shown in the first cycle with busy low again, and the next word
// may be accepted in that same cycle. A reserve walks the fence table
// through one RAM read port, with a read and a check state per entry, at
// most once to retire completed fences and once to search for a freeing
// fence. The adder/comparator path works on one table entry per step.
// Writing buffer_size (cfg_we_i) clears the write offset, usable space,
// consumer position and the fence table; write it only while idle.
// Reset sets buffer_size to 65536 and empties the table. The fence table
// RAM holds undefined data until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module fenced_ring_buffer_allocator #(
  parameter int unsigned FENCE_SLOTS = frba_pkg::FENCE_SLOTS_DEF,
  parameter int unsigned MAX_ALIGN   = frba_pkg::MAX_ALIGN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [frba_pkg::OFF_W-1:0]    cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [frba_pkg::OFF_W-1:0]    byte_count_i,
  input  logic [frba_pkg::ALIGN_W-1:0]  align_bytes_i,
  input  logic [frba_pkg::FENCE_W-1:0]  submit_fence_i,
  input  logic [frba_pkg::FENCE_W-1:0]  done_fence_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [frba_pkg::OFF_W-1:0]    start_offset_o,
  output logic [frba_pkg::OFF_W-1:0]    free_space_o,
  output logic [frba_pkg::FENCE_W-1:0]  wait_fence_o
);

  localparam int unsigned IW  = $clog2(FENCE_SLOTS);
  localparam int unsigned CW  = $clog2(FENCE_SLOTS + 1);
  localparam int unsigned OW  = frba_pkg::OFF_W;
  localparam int unsigned FW  = frba_pkg::FENCE_W;
  localparam int unsigned EW  = FW + OW;
  localparam int unsigned AW  = 13;
  localparam logic [CW-1:0] SLOTS_C = CW'(FENCE_SLOTS);

  frba_pkg::fsm_e state_q, state_d;

  logic [OW-1:0] bsize_q, wo_q, wo_d, us_q, us_d, cp_q, cp_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic          cmd_q;
  logic [OW-1:0] count_q;
  logic [AW-1:0] align_q;
  logic [FW-1:0] submit_q, done_q;
  logic [2:0]    stat_q, stat_d;
  logic [OW-1:0] space_q, space_d;
  logic [FW-1:0] wf_q, wf_d;
  logic [OW-1:0] noff_q, noff_d, nsp_q, nsp_d, ngpu_q, ngpu_d;
  logic          nall_d;
  logic          done_q2, done_d;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [FW-1:0] rval;
  logic [OW-1:0] roff;

  frba_ram #(.WIDTH(EW), .DEPTH(FENCE_SLOTS)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rval = rdata[EW-1:OW];
  assign roff = rdata[OW-1:0];

  function automatic logic [IW-1:0] slot_of(logic [IW-1:0] h, logic [CW-1:0] i);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, i};
    if (s >= (CW+1)'(FENCE_SLOTS)) s = s - (CW+1)'(FENCE_SLOTS);
    return IW'(s);
  endfunction

  logic [AW-1:0] align_eff;
  always_comb begin
    logic [AW-1:0] a;
    a = AW'(align_bytes_i);
    if (a > AW'(MAX_ALIGN)) a = AW'(MAX_ALIGN);
    align_eff = AW'(1);
    for (int b = AW - 1; b >= 0; b--) begin
      if (a[b] && align_eff == AW'(1) && b != 0) align_eff = AW'(1) << b;
    end
  end

  function automatic logic [OW-1:0] sat_sub(logic [OW-1:0] a, logic [OW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  logic [OW:0]   req;
  logic [OW-1:0] wo_al;
  logic [OW:0]   wo_al_w;
  assign req     = {1'b0, count_q} + (OW+1)'(align_q);
  assign wo_al_w = ({1'b0, wo_q} + (OW+1)'(align_q) - 1'b1) & ~((OW+1)'(align_q) - 1'b1);
  assign wo_al   = wo_al_w[OW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frba_pkg::S_IDLE;
      bsize_q <= frba_pkg::BUF_SIZE_RST;
      wo_q    <= '0;
      us_q    <= '0;
      cp_q    <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
      done_q2 <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q2 <= done_d;
      if (cfg_we_i) begin
        bsize_q <= cfg_wdata_i;
        wo_q    <= '0;
        us_q    <= '0;
        cp_q    <= '0;
        head_q  <= '0;
        cnt_q   <= '0;
      end else begin
        wo_q   <= wo_d;
        us_q   <= us_d;
        cp_q   <= cp_d;
        head_q <= head_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q    <= command_i;
      count_q  <= byte_count_i;
      align_q  <= align_eff;
      submit_q <= submit_fence_i;
      done_q   <= done_fence_i;
    end
    idx_q   <= idx_d;
    stat_q  <= stat_d;
    space_q <= space_d;
    wf_q    <= wf_d;
    noff_q  <= noff_d;
    nsp_q   <= nsp_d;
    ngpu_q  <= ngpu_d;
  end

  assign busy = (state_q != frba_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frba_pkg::S_IDLE:    if (start) state_d = frba_pkg::S_CHECK;
      frba_pkg::S_CHECK: begin
        if (cmd_q || count_q > bsize_q) state_d = frba_pkg::S_DONE;
        else if (wo_q == cp_q) state_d = frba_pkg::S_PLACE;
        else if (cnt_q != '0) state_d = frba_pkg::S_LASTRD;
        else state_d = frba_pkg::S_PUSH;
      end
      frba_pkg::S_LASTRD:  state_d = frba_pkg::S_LASTCHK;
      frba_pkg::S_LASTCHK: state_d = (rval == submit_q) ? frba_pkg::S_PLACE
                                                         : frba_pkg::S_RETRD;
      frba_pkg::S_RETRD:   state_d = (idx_q < cnt_q) ? frba_pkg::S_RETCHK
                                                     : frba_pkg::S_PUSH;
      frba_pkg::S_RETCHK:  state_d = (done_q >= rval) ? frba_pkg::S_RETRD
                                                      : frba_pkg::S_PUSH;
      frba_pkg::S_PUSH:    state_d = (cnt_q - idx_q >= SLOTS_C) ? frba_pkg::S_DONE
                                                                : frba_pkg::S_PLACE;
      frba_pkg::S_PLACE:   state_d = (stat_d == 3'(frba_pkg::ST_SUBMIT))
                                     ? frba_pkg::S_SRCHRD : frba_pkg::S_DONE;
      frba_pkg::S_SRCHRD:  state_d = (idx_q < cnt_q) ? frba_pkg::S_SRCHCHK
                                                     : frba_pkg::S_DONE;
      frba_pkg::S_SRCHCHK: state_d = nall_d ? frba_pkg::S_FIX : frba_pkg::S_SRCHRD;
      frba_pkg::S_FIX:     state_d = frba_pkg::S_DONE;
      frba_pkg::S_DONE:    state_d = frba_pkg::S_IDLE;
      default:             state_d = frba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    logic [OW:0] sum;
    logic [OW-1:0] room;
    logic [OW:0] need;
    logic [OW-1:0] d;
    wo_d = wo_q; us_d = us_q; cp_d = cp_q; head_d = head_q; cnt_d = cnt_q;
    idx_d = idx_q; stat_d = stat_q; space_d = space_q; wf_d = wf_q;
    noff_d = noff_q; nsp_d = nsp_q; ngpu_d = ngpu_q; nall_d = 1'b0;
    done_d = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = slot_of(head_q, idx_q);
    sum = '0; room = '0; need = '0; d = '0;
    unique case (state_q)
      frba_pkg::S_IDLE: begin
        stat_d = 3'(frba_pkg::ST_PLACED);
        space_d = '0;
        wf_d = '0;
        idx_d = '0;
      end
      frba_pkg::S_CHECK: begin
        if (cmd_q) begin
          sum = {1'b0, wo_q} + {1'b0, count_q};
          if (sum > {1'b0, bsize_q} || count_q > us_q) begin
            stat_d = 3'(frba_pkg::ST_OVERRUN);
          end else begin
            wo_d = sum[OW-1:0];
            us_d = us_q - count_q;
            space_d = us_q - count_q;
          end
        end else if (count_q > bsize_q) begin
          stat_d = 3'(frba_pkg::ST_TOO_LARGE);
        end
        raddr = slot_of(head_q, cnt_q - 1'b1);
        idx_d = '0;
      end
      frba_pkg::S_LASTRD: raddr = slot_of(head_q, cnt_q - 1'b1);
      frba_pkg::S_LASTCHK: begin
        if (rval == submit_q) begin
          we = 1'b1;
          waddr = slot_of(head_q, cnt_q - 1'b1);
          wdata = {rval, wo_q};
        end
      end
      frba_pkg::S_RETRD: ;
      frba_pkg::S_RETCHK: begin
        if (done_q >= rval) begin
          cp_d = roff;
          idx_d = idx_q + 1'b1;
          raddr = slot_of(head_q, idx_q + 1'b1);
        end
      end
      frba_pkg::S_PUSH: begin
        head_d = slot_of(head_q, idx_q);
        cnt_d = cnt_q - idx_q;
        if (cnt_q - idx_q >= SLOTS_C) begin
          stat_d = 3'(frba_pkg::ST_TABLE_FULL);
        end else begin
          we = 1'b1;
          waddr = slot_of(slot_of(head_q, idx_q), cnt_q - idx_q);
          wdata = {submit_q, wo_q};
          cnt_d = cnt_q - idx_q + 1'b1;
        end
      end
      frba_pkg::S_PLACE: begin
        stat_d = 3'(frba_pkg::ST_SUBMIT);
        idx_d = '0;
        raddr = slot_of(head_q, '0);
        if (wo_q >= cp_q) begin
          need = (wo_q != '0) ? req : {1'b0, count_q};
          if (need <= {1'b0, sat_sub(bsize_q, wo_q)}) begin
            wo_d = wo_al; us_d = sat_sub(bsize_q, wo_al);
            stat_d = 3'(frba_pkg::ST_PLACED); space_d = us_d;
          end else if (req < {1'b0, cp_q}) begin
            wo_d = '0; us_d = cp_q;
            stat_d = 3'(frba_pkg::ST_PLACED); space_d = cp_q;
          end
        end
        if (stat_d == 3'(frba_pkg::ST_SUBMIT) && wo_q < cp_q &&
            req < {1'b0, cp_q - wo_q}) begin
          wo_d = wo_al; us_d = sat_sub(cp_q, wo_al);
          stat_d = 3'(frba_pkg::ST_PLACED); space_d = us_d;
        end
      end
      frba_pkg::S_SRCHRD: ;
      frba_pkg::S_SRCHCHK: begin
        room = sat_sub(bsize_q, wo_q);
        if (wo_q == roff) begin
          nall_d = 1'b1; noff_d = '0; nsp_d = bsize_q; ngpu_d = '0;
        end else if (wo_q > roff) begin
          if ({1'b0, room} >= req) begin
            nall_d = 1'b1; noff_d = wo_q; nsp_d = room; ngpu_d = roff;
          end else if ({1'b0, roff} > req) begin
            nall_d = 1'b1; noff_d = '0; nsp_d = roff; ngpu_d = roff;
          end
        end else if ({1'b0, roff - wo_q} > req) begin
          nall_d = 1'b1; noff_d = wo_q; nsp_d = roff - wo_q; ngpu_d = roff;
        end
        if (nall_d) begin
          if (rval == submit_q) begin
            nall_d = 1'b0;
            idx_d = cnt_q;
          end else begin
            wf_d = rval;
            if (wo_q == roff) begin
              head_d = slot_of(head_q, cnt_q); cnt_d = '0;
            end else begin
              head_d = slot_of(head_q, idx_q + 1'b1);
              cnt_d = cnt_q - idx_q - 1'b1;
            end
            wo_d = noff_d; us_d = nsp_d; cp_d = ngpu_d;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          raddr = slot_of(head_q, idx_q + 1'b1);
        end
      end
      frba_pkg::S_FIX: begin
        d = wo_al - wo_q;
        wo_d = wo_al;
        us_d = sat_sub(us_q, d);
        stat_d = 3'(frba_pkg::ST_WAITED);
        space_d = sat_sub(us_q, d);
      end
      frba_pkg::S_DONE: done_d = 1'b1;
      default: ;
    endcase
  end

  assign done_o         = done_q2;
  assign status_o       = stat_q;
  assign start_offset_o = wo_q;
  assign free_space_o   = space_q;
  assign wait_fence_o   = wf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SLOTS_C) else $error("fence count above table size");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

endmodule

>>> hdl/frba_ram.sv
// ----------------------------------------------------------------------------
// frba_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module frba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
